// ----- hdl/csrc_pkg.sv -----
// shared types, constants and the quarter-cosine table function for the camera space transform
package csrc_pkg;

    localparam int unsigned VIEW_ANG_W         = 10;
    localparam int unsigned QUARTER_STEPS_DEF  = 256;
    localparam int unsigned CFG_INDEX_BITS     = 2;
    localparam int unsigned TAYLOR_TERMS       = 14;
    localparam logic [63:0] PI_Q30             = 64'd3373259426;
    localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182,
        64'd240, 64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756
    };

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CAMERA_X   = 2'd0,
        CFG_CAMERA_Y   = 2'd1,
        CFG_VIEW_ANGLE = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quadrant;

    typedef struct packed {
        logic [15:0] object_x;
        logic [15:0] object_y;
    } t_obj_in;

    typedef struct packed {
        logic               visible;
        logic signed [15:0] depth;
        logic signed [15:0] lateral;
    } t_obj_out;

    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] c;
        logic [15:0] s;
        t_quadrant   quadrant;
        logic        fine_zero;
    } t_rot_op;

    // cos(i * pi / 2^(qbits+1)) in 0.16, taylor series in q30
    function automatic logic [15:0] cos_entry(input int unsigned i, input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (64'(i) * PI_Q30 + (64'd1 << qbits)) >> (qbits + 1);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = term;
        for (int k = 0; k < TAYLOR_TERMS; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k % 2 == 1) begin
                sum = sum + term;
            end else begin
                sum = sum - term;
            end
        end
        if (sum > (64'd1 << 32)) begin
            return 16'd0;
        end
        r = (sum + (64'd1 << 13)) >> 14;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        return r[15:0];
    endfunction

endpackage

// ----- hdl/csrc_rotate.sv -----
// rotation products, quadrant swap and view cone test for one translated position
module csrc_rotate
    import csrc_pkg::*;
(
    input  t_rot_op  i_op,
    output t_obj_out o_res
);

    logic signed [32:0] w_p_xc;
    logic signed [32:0] w_p_ys;
    logic signed [32:0] w_p_yc;
    logic signed [32:0] w_p_xs;
    logic [15:0] w_u;
    logic [15:0] w_v;
    logic [15:0] w_dep;
    logic [15:0] w_lat;
    logic [15:0] w_ndep;

    assign w_p_xc = $signed(i_op.tx) * $signed({1'b0, i_op.c});
    assign w_p_ys = $signed(i_op.ty) * $signed({1'b0, i_op.s});
    assign w_p_yc = $signed(i_op.ty) * $signed({1'b0, i_op.c});
    assign w_p_xs = $signed(i_op.tx) * $signed({1'b0, i_op.s});

    always_comb begin
        if (i_op.fine_zero) begin
            w_u = i_op.tx;
            w_v = i_op.ty;
        end else begin
            w_u = w_p_xc[31:16] + w_p_ys[31:16];
            w_v = w_p_yc[31:16] - w_p_xs[31:16];
        end
        case (i_op.quadrant)
            QUAD_0: begin
                w_dep = w_u;
                w_lat = w_v;
            end
            QUAD_1: begin
                w_dep = w_v;
                w_lat = 16'd0 - w_u;
            end
            QUAD_2: begin
                w_dep = 16'd0 - w_u;
                w_lat = 16'd0 - w_v;
            end
            default: begin
                w_dep = 16'd0 - w_v;
                w_lat = w_u;
            end
        endcase
        w_ndep        = 16'd0 - w_dep;
        o_res.depth   = $signed(w_dep);
        o_res.lateral = $signed(w_lat);
        o_res.visible = ($signed(w_lat) < $signed(w_dep)) && ($signed(w_lat) > $signed(w_ndep));
    end

endmodule

// ----- hdl/camera_space_rotate_cull_top.sv -----
// top level: camera translate, rotate into camera space and view cone cull
//
// requests enter on i_in_valid / o_in_ready with object_x, object_y (8.8 fixed point)
// and leave on o_out_valid / i_out_ready with visible, depth and lateral.
// the configuration channel (i_cfg_valid / o_cfg_ready) writes camera_x, camera_y
// and view_angle by index; it is always ready, unknown indexes are dropped.
// the user must change configuration only while no request is in flight; the
// block itself does not enforce it. an accepted request is held in the stage one
// register, then in the output register: stage one subtracts the camera and reads
// the cosine table, stage two does the four 16x16 products, the quadrant swap and
// the cone compare into the output register. throughput is one request per cycle
// while results are taken; stage one fills whenever it is empty, and o_in_ready
// drops in the same cycle that stage one is full and the output holds an untaken one.
// reset clears the stage valid bits and the configuration registers to zero;
// the cosine table is constant logic and needs no fill.
module camera_space_rotate_cull_top
    import csrc_pkg::*;
#(
    parameter int unsigned QUARTER_STEPS = QUARTER_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [15:0]               i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  t_obj_in                   i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output t_obj_out                  o_out_data
);

    localparam int unsigned Q_BITS = $clog2(QUARTER_STEPS);

    logic [15:0]           r_camera_x;
    logic [15:0]           r_camera_y;
    logic [VIEW_ANG_W-1:0] r_view_angle;
    logic                  r_s1_valid;
    t_rot_op               r_s1;
    t_rot_op               n_s1;
    logic                  r_out_valid;
    t_obj_out              r_out;
    t_obj_out              w_res;
    logic                  w_out_free;
    logic                  w_s1_free;
    logic [Q_BITS-1:0]     w_fine;
    logic [Q_BITS-1:0]     w_fine_neg;
    logic [VIEW_ANG_W+1:0] w_angle_ext;
    logic [15:0]           w_cos_rom [QUARTER_STEPS];

    for (genvar g = 0; g < QUARTER_STEPS; g++) begin : g_rom
        assign w_cos_rom[g] = cos_entry(g, Q_BITS);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_x   <= '0;
            r_camera_y   <= '0;
            r_view_angle <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CAMERA_X:   r_camera_x   <= i_cfg_data;
                CFG_CAMERA_Y:   r_camera_y   <= i_cfg_data;
                CFG_VIEW_ANGLE: r_view_angle <= i_cfg_data[VIEW_ANG_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s1_free   = !r_s1_valid || w_out_free;
    assign o_in_ready  = w_s1_free;

    assign w_angle_ext = {2'b00, r_view_angle};
    assign w_fine      = r_view_angle[Q_BITS-1:0];
    assign w_fine_neg  = '0 - w_fine;

    always_comb begin
        n_s1.tx        = i_in_data.object_x - r_camera_x;
        n_s1.ty        = i_in_data.object_y - r_camera_y;
        n_s1.c         = w_cos_rom[w_fine];
        n_s1.s         = w_cos_rom[w_fine_neg];
        n_s1.quadrant  = t_quadrant'(w_angle_ext[Q_BITS +: 2]);
        n_s1.fine_zero = (w_fine == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in_valid) begin
            r_s1 <= n_s1;
        end
    end

    csrc_rotate u_rotate (
        .i_op  (r_s1),
        .o_res (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_s1_valid)
        else $error("accepted request did not reach stage one");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_out_free |=> o_out_valid)
        else $error("stage one request lost on its way to the output");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_out_free && r_s1.fine_zero && r_s1.quadrant == QUAD_0
        |=> o_out_data.depth == $signed($past(r_s1.tx))
            && o_out_data.lateral == $signed($past(r_s1.ty)))
        else $error("zero fine angle did not pass translated values through");

    a_visible_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.visible |-> o_out_data.depth > 16'sd0)
        else $error("visible object with non-positive depth");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// testbench for camera_space_rotate_cull_top: random objects and views, checked against an in-bench predictor
module tb_top;
    import csrc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SERIES_TERMS = 14;
    localparam logic [63:0] PI_FIX       = 64'd3373259426;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int unsigned PHASES       = 14;
    localparam int unsigned PHASE_OBJS   = 96;

    logic                      i_clk;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [15:0]               i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    t_obj_in                   i_in_data   = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    t_obj_out                  o_out_data;

    t_obj_in     pending_objs[$];
    t_obj_out    view_expect[$];
    logic [15:0] cos_tab[QUARTER_STEPS_DEF];
    logic [15:0] cam_x    = '0;
    logic [15:0] cam_y    = '0;
    logic [9:0]  view_ang = '0;
    logic        in_taken = 1'b0;
    logic        idle_on  = 1'b1;
    int unsigned send_gap    = 0;
    int unsigned recv_stall  = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;

    camera_space_rotate_cull_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [15:0] quarter_cos(input int unsigned step);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] rnd;
        ang    = (64'(step) * PI_FIX + 64'(QUARTER_STEPS_DEF)) / (64'd2 * 64'(QUARTER_STEPS_DEF));
        ang_sq = (ang * ang) >> 30;
        term   = 64'd1 << 30;
        acc    = term;
        for (int k = 0; k < SERIES_TERMS; k++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * k + 1) * (2 * k + 2));
            if (k % 2 == 1) begin
                acc = acc + term;
            end else begin
                acc = acc - term;
            end
        end
        if (acc > (64'd1 << 32)) begin
            return 16'd0;
        end
        rnd = (acc + (64'd1 << 13)) >> 14;
        if (rnd > 64'd65535) begin
            rnd = 64'd65535;
        end
        return rnd[15:0];
    endfunction

    // signed by unsigned product, floor over 2^16
    function automatic logic [15:0] frac_mul(input logic [15:0] a, input logic [15:0] b);
        logic [63:0] prod;
        prod = 64'($signed(a)) * 64'(b);
        return prod[31:16];
    endfunction

    function automatic t_obj_out predict_view(input t_obj_in obj);
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] dep;
        logic [15:0] lat;
        logic [15:0] neg_dep;
        logic [1:0]  qbits;
        int unsigned fine;
        t_quadrant   quad;
        t_obj_out    res;
        tx    = obj.object_x - cam_x;
        ty    = obj.object_y - cam_y;
        qbits = 2'(int'(view_ang) / QUARTER_STEPS_DEF);
        quad  = t_quadrant'(qbits);
        fine  = int'(view_ang) % QUARTER_STEPS_DEF;
        if (fine == 0) begin
            u = tx;
            v = ty;
        end else begin
            u = frac_mul(tx, cos_tab[fine]) + frac_mul(ty, cos_tab[QUARTER_STEPS_DEF - fine]);
            v = frac_mul(ty, cos_tab[fine]) - frac_mul(tx, cos_tab[QUARTER_STEPS_DEF - fine]);
        end
        case (quad)
            QUAD_0: begin
                dep = u;
                lat = v;
            end
            QUAD_1: begin
                dep = v;
                lat = 16'd0 - u;
            end
            QUAD_2: begin
                dep = 16'd0 - u;
                lat = 16'd0 - v;
            end
            default: begin
                dep = 16'd0 - v;
                lat = u;
            end
        endcase
        neg_dep     = 16'd0 - dep;
        res.depth   = dep;
        res.lateral = lat;
        res.visible = ($signed(lat) < $signed(dep)) && ($signed(lat) > $signed(neg_dep));
        return res;
    endfunction

    task automatic queue_obj(input logic [15:0] x, input logic [15:0] y);
        t_obj_in obj;
        obj.object_x = x;
        obj.object_y = y;
        pending_objs.push_back(obj);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_view(input logic [15:0] cx, input logic [15:0] cy,
                                input logic [15:0] ang_raw, input bit spare);
        if (spare) begin
            write_reg(CFG_SPARE, 16'($urandom));
        end
        write_reg(CFG_CAMERA_X, cx);
        write_reg(CFG_CAMERA_Y, cy);
        write_reg(CFG_VIEW_ANGLE, ang_raw);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (pending_objs.size() != 0 || i_in_valid || view_expect.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_objs.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
                send_gap   <= $urandom_range(0, 13);
                i_in_valid <= 1'b0;
            end else if (pending_objs.size() != 0) begin
                i_in_data  <= pending_objs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall  <= recv_stall - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            recv_stall  <= $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : watch
        t_obj_out want;
        t_obj_out got;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (view_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: visible %0d depth %0d lateral %0d",
                                 got.visible, got.depth, got.lateral);
                    end
                end else begin
                    want = view_expect.pop_front();
                    if (got.visible !== want.visible || got.depth !== want.depth ||
                        got.lateral !== want.lateral) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch vis/dep/lat: want %0d %0d %0d, got %0d %0d %0d",
                                     want.visible, want.depth, want.lateral,
                                     got.visible, got.depth, got.lateral);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                view_expect.push_back(predict_view(i_in_data));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_CAMERA_X:   cam_x = i_cfg_data;
                    CFG_CAMERA_Y:   cam_y = i_cfg_data;
                    CFG_VIEW_ANGLE: view_ang = i_cfg_data[VIEW_ANG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin : sequencer
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] off;
        logic [15:0] off2;
        logic [9:0]  ang;
        int unsigned kind;
        logic [9:0]  angle_plan[8];
        angle_plan = '{10'd1023, 10'd256, 10'd512, 10'd768, 10'd255, 10'd257, 10'd384, 10'd0};
        for (int i = 0; i < QUARTER_STEPS_DEF; i++) begin
            cos_tab[i] = quarter_cos(i);
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset view: no rotation, camera at origin
        queue_obj(16'h0000, 16'h0000);
        queue_obj(16'hFFFF, 16'hFFFF);
        queue_obj(16'h8000, 16'h0000);
        queue_obj(16'h0000, 16'h8000);
        queue_obj(16'h8000, 16'h8000);
        queue_obj(16'h7FFF, 16'h7FFF);
        queue_obj(16'h0100, 16'h0080);
        queue_obj(16'h0100, 16'hFF80);
        queue_obj(16'h0100, 16'h0100);
        queue_obj(16'hFF00, 16'h0000);
        queue_obj(16'h7FFF, 16'h8000);
        queue_obj(16'h5555, 16'hAAAA);
        settle();

        // angle with junk upper bits, ignored index written too
        program_view(16'hFFFF, 16'hFFFF, 16'hFC01, 1'b1);
        queue_obj(16'h0000, 16'h0000);
        queue_obj(16'hFFFF, 16'hFFFF);
        queue_obj(16'h7FFF, 16'h7FFF);
        queue_obj(16'h8000, 16'h7FFF);
        queue_obj(16'hAAAA, 16'h5555);
        queue_obj(16'h0101, 16'h0101);
        queue_obj(16'h8001, 16'h8001);
        queue_obj(16'hFFFE, 16'h0000);
        queue_obj(16'h0000, 16'hFFFE);
        queue_obj(16'h4000, 16'hC000);
        queue_obj(16'hC000, 16'h4000);
        queue_obj(16'h7FFF, 16'h0000);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            ang = (ph < 8) ? angle_plan[ph] : 10'($urandom_range(0, 1023));
            if (ph % 4 == 0) begin
                cx = 16'h0000;
                cy = 16'h0000;
            end else if (ph % 4 == 1) begin
                cx = 16'hFFFF;
                cy = 16'hFFFF;
            end else begin
                cx = 16'($urandom);
                cy = 16'($urandom);
            end
            idle_on = (ph < PHASES - 2) && (ph % 3 != 2);
            program_view(cx, cy, {6'($urandom_range(0, 63)), ang}, $urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_OBJS; n++) begin
                kind = $urandom_range(0, 3);
                if (kind < 2) begin
                    queue_obj(16'($urandom), 16'($urandom));
                end else if (kind == 2) begin
                    off  = 16'($urandom_range(0, 4095)) - 16'd2048;
                    off2 = 16'($urandom_range(0, 4095)) - 16'd2048;
                    queue_obj(cx + off, cy + off2);
                end else begin
                    off = 16'($urandom);
                    queue_obj(cx + off, ($urandom_range(0, 1) == 1) ? cy + off : cy - off);
                end
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        mismatches += view_expect.size();
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
